// ===== rtl/core/chs_pkg.sv =====
`default_nettype none

package chs_pkg;

	// width of the bucket count register and its value after reset
	localparam int unsigned CFG_W = 8;
	localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = 8'd100;

	// operation carried by an input beat
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_SEARCH = 1'b1
	} mode_t;

	// outcome carried by a result beat
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_SEARCH    = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/chs_item_if.sv =====
`default_nettype none

interface chs_item_if #(
	parameter int unsigned KEY_BITS = 31
);
	import chs_pkg::*;

	logic                valid;
	logic                ready;
	mode_t               mode;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/chs_result_if.sv =====
`default_nettype none

interface chs_result_if #(
	parameter int unsigned BKT_W = 7
);
	import chs_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic             found;
	logic [BKT_W-1:0] bucket;

	modport source (output valid, output status, output found, output bucket, input ready);
	modport sink   (input valid, input status, input found, input bucket, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/chained_hash_set.sv =====
`default_nettype none

// Set of keys in a hash table with separate chaining. Each item beat is an
// insert or a search; each yields one result beat with the status, the found
// flag and the bucket index (key modulo the bucket count, which reads as 1 when
// written 0 and saturates at MAX_BUCKETS). One item is in work at a time: the
// modulo runs one key bit per cycle, the bucket head is read in the S_HEAD and
// S_LOAD states, every chain node visited passes S_STEP and S_NODE (one read of
// the node memory and the key compare), a walk that runs off its chain takes
// one more S_STEP for that end check, and S_DONE finishes the item, held there
// while the output register still holds an unaccepted result. A new item is
// taken while the previous result still waits in the output register. After
// reset a clearing pass over all MAX_BUCKETS heads empties the bucket heads; no
// item is taken during it, bucket count writes are.
module chained_hash_set #(
	parameter int unsigned MAX_BUCKETS = 128,
	parameter int unsigned POOL_SIZE   = 256,
	parameter int unsigned KEY_BITS    = 31
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [chs_pkg::CFG_W-1:0]    cfg_wdata,
	chs_item_if.sink                    item,
	chs_result_if.source                result
);
	import chs_pkg::*;

	localparam int unsigned BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int unsigned PTR_W = $clog2(POOL_SIZE + 1);
	localparam int unsigned NIX_W = $clog2(POOL_SIZE);
	localparam int unsigned CNT_W = $clog2(KEY_BITS + 1);
	localparam int unsigned NODE_W = KEY_BITS + PTR_W;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_HEAD  = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_STEP  = 8'b0010_0000,
		S_NODE  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    bucket_count_q;
	logic [CFG_W-1:0]    eff_q;
	logic [CFG_W-1:0]    rem_q;
	logic [KEY_BITS-1:0] div_sh_q;
	logic [CNT_W-1:0]    div_cnt_q;
	mode_t               mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PTR_W-1:0]    cur_q;
	logic [PTR_W-1:0]    head_ptr_q;
	logic [PTR_W-1:0]    steps_q;
	logic [PTR_W-1:0]    used_q;
	logic                present_q;
	logic [BKT_W-1:0]    clr_cnt_q;

	logic                res_valid_q;
	status_t             res_status_q;
	logic                res_found_q;
	logic [BKT_W-1:0]    res_bucket_q;

	// memories: bucket heads and the node pool (key and link in one word)
	logic [PTR_W-1:0]    head_mem [MAX_BUCKETS];
	logic [NODE_W-1:0]   node_mem [POOL_SIZE];
	logic [PTR_W-1:0]    head_rdata;
	logic [NODE_W-1:0]   node_rdata;

	logic                item_beat;
	logic                done_fire;
	logic                ins_fire;
	logic [CFG_W-1:0]    eff_cfg;
	logic [CFG_W:0]      div_trial;
	logic [CFG_W:0]      div_eff;
	logic [CFG_W-1:0]    rem_nx;
	logic [BKT_W-1:0]    bkt;
	logic                walk_end;
	logic [KEY_BITS-1:0] node_key;
	logic [PTR_W-1:0]    node_link;
	logic                head_we;
	logic [BKT_W-1:0]    head_waddr;
	logic [PTR_W-1:0]    head_wdata;
	status_t             status_nx;
	logic                found_nx;

	assign item_beat = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);

	// effective divisor: zero reads as one, saturate at the bucket depth
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_cfg = CFG_W'(1);
		end else if (int'(bucket_count_q) > int'(MAX_BUCKETS)) begin
			eff_cfg = CFG_W'(MAX_BUCKETS);
		end else begin
			eff_cfg = bucket_count_q;
		end
	end

	// restoring modulo step, one key bit per cycle
	assign div_trial = {rem_q, div_sh_q[KEY_BITS-1]};
	assign div_eff   = {1'b0, eff_q};
	assign rem_nx    = (div_trial >= div_eff) ? CFG_W'(div_trial - div_eff)
	                                          : CFG_W'(div_trial);
	assign bkt       = BKT_W'(rem_q);

	// chain walk stops on null, out-of-pool pointer or step guard
	assign walk_end = (cur_q == '0) || (int'(cur_q) > int'(POOL_SIZE))
	                  || (steps_q >= used_q);
	assign node_key  = node_rdata[NODE_W-1 -: KEY_BITS];
	assign node_link = node_rdata[PTR_W-1:0];

	// outcome of the item
	always_comb begin
		found_nx = 1'b0;
		ins_fire = 1'b0;
		priority if (mode_q == MODE_SEARCH) begin
			status_nx = ST_SEARCH;
			found_nx  = present_q;
		end else if (present_q) begin
			status_nx = ST_DUPLICATE;
			found_nx  = 1'b1;
		end else if (int'(used_q) >= int'(POOL_SIZE)) begin
			status_nx = ST_FULL;
		end else begin
			status_nx = ST_INSERTED;
			ins_fire  = 1'b1;
		end
	end

	assign done_fire = (state_q == S_DONE) && (!res_valid_q || result.ready);

	// head memory write port: clearing pass or new chain head
	assign head_we    = (state_q == S_CLEAR) || (done_fire && ins_fire);
	assign head_waddr = (state_q == S_CLEAR) ? clr_cnt_q : bkt;
	assign head_wdata = (state_q == S_CLEAR) ? '0 : PTR_W'(used_q + 1'b1);

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rdata <= head_mem[bkt];
	end

	always_ff @(posedge clk) begin
		if (done_fire && ins_fire) begin
			node_mem[NIX_W'(used_q)] <= {key_q, head_ptr_q};
		end
		node_rdata <= node_mem[NIX_W'(cur_q - 1'b1)];
	end

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= DEFAULT_BUCKETS;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			used_q    <= '0;
			div_cnt_q <= '0;
			steps_q   <= '0;
			present_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (int'(clr_cnt_q) == int'(MAX_BUCKETS) - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_beat) begin
						div_cnt_q <= CNT_W'(KEY_BITS);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNT_W'(1)) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					steps_q   <= '0;
					present_q <= 1'b0;
					state_q   <= S_STEP;
				end
				S_STEP: begin
					state_q <= walk_end ? S_DONE : S_NODE;
				end
				S_NODE: begin
					if (node_key == key_q) begin
						present_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						if (ins_fire) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, divider datapath and walk pointer
	always_ff @(posedge clk) begin
		if (item_beat) begin
			mode_q   <= item.mode;
			key_q    <= item.key;
			div_sh_q <= item.key;
			eff_q    <= eff_cfg;
			rem_q    <= '0;
		end else if (state_q == S_DIV) begin
			rem_q    <= rem_nx;
			div_sh_q <= {div_sh_q[KEY_BITS-2:0], 1'b0};
		end
		if (state_q == S_LOAD) begin
			cur_q      <= head_rdata;
			head_ptr_q <= head_rdata;
		end else if (state_q == S_NODE) begin
			cur_q <= node_link;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			res_status_q <= status_nx;
			res_found_q  <= found_nx;
			res_bucket_q <= bkt;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.status = res_status_q;
	assign result.found  = res_found_q;
	assign result.bucket = res_bucket_q;

`ifndef SYNTHESIS
	// remainder stays below the divisor throughout the modulo
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < eff_q))
		else $error("modulo remainder not below divisor");

	// walk never takes more steps than there are nodes
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP || state_q == S_NODE) |-> (steps_q <= used_q))
		else $error("chain walk exceeded node count");

	// a linked node bumps the pool count by exactly one
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && ins_fire) |=> (used_q == $past(used_q) + 1'b1))
		else $error("pool count did not advance on insert");

	// table full is reported only with the pool used up
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && status_nx == ST_FULL) |-> (int'(used_q) == int'(POOL_SIZE)))
		else $error("table full reported with free nodes");
`endif

endmodule

`default_nettype wire
